// ===== hdl/omv_pkg.sv =====
// Shared types, mixing coefficients and the per-degree cosine table of the omni wheel mixer.
`timescale 1ns / 1ps
`default_nettype none

package omv_pkg;

	typedef struct packed {
		logic              mode;
		logic signed [15:0] heading;
		logic signed [15:0] speed;
		logic signed [15:0] turn;
		logic signed [15:0] x_cmd;
		logic signed [15:0] y_cmd;
	} omv_in_t;

	typedef struct packed {
		logic signed [23:0] wheel_a;
		logic signed [23:0] wheel_b;
		logic signed [23:0] wheel_c;
		logic               stop_now;
	} omv_out_t;

	localparam int COMP_W  = 17;  // x, y, w components: magnitude up to 32768
	localparam int COEF_W  = 15;
	localparam int PROD_W  = COMP_W + COEF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd40;
	localparam int HEADING_MAX = 359;

	// Q16 mixing coefficients, polar and direct sets
	localparam logic signed [COEF_W-1:0] CX_POLAR  = 15'sd3736;
	localparam logic signed [COEF_W-1:0] CW_POLAR  = 15'sd9241;
	localparam logic signed [COEF_W-1:0] CX_DIRECT = 15'sd3670;
	localparam logic signed [COEF_W-1:0] CW_DIRECT = 15'sd9175;
	localparam logic signed [COEF_W-1:0] CY_ALL    = 15'sd2163;
	localparam logic signed [COEF_W-1:0] CB_ALL    = 15'sd4260;

	// round(cos(d degrees) * 65536), d = 0..90
	localparam logic [16:0] COS_Q16_TAB [0:90] = '{
		17'd65536, 17'd65526, 17'd65496, 17'd65446, 17'd65376,
		17'd65287, 17'd65177, 17'd65048, 17'd64898, 17'd64729,
		17'd64540, 17'd64332, 17'd64104, 17'd63856, 17'd63589,
		17'd63303, 17'd62997, 17'd62672, 17'd62328, 17'd61966,
		17'd61584, 17'd61183, 17'd60764, 17'd60326, 17'd59870,
		17'd59396, 17'd58903, 17'd58393, 17'd57865, 17'd57319,
		17'd56756, 17'd56175, 17'd55578, 17'd54963, 17'd54332,
		17'd53684, 17'd53020, 17'd52339, 17'd51643, 17'd50931,
		17'd50203, 17'd49461, 17'd48703, 17'd47930, 17'd47143,
		17'd46341, 17'd45525, 17'd44695, 17'd43852, 17'd42995,
		17'd42126, 17'd41243, 17'd40348, 17'd39441, 17'd38521,
		17'd37590, 17'd36647, 17'd35693, 17'd34729, 17'd33754,
		17'd32768, 17'd31772, 17'd30767, 17'd29753, 17'd28729,
		17'd27697, 17'd26656, 17'd25607, 17'd24550, 17'd23486,
		17'd22415, 17'd21336, 17'd20252, 17'd19161, 17'd18064,
		17'd16962, 17'd15855, 17'd14742, 17'd13626, 17'd12505,
		17'd11380, 17'd10252, 17'd9121,  17'd7987,  17'd6850,
		17'd5712,  17'd4572,  17'd3430,  17'd2287,  17'd1144,
		17'd0
	};

endpackage

`default_nettype wire

// ===== hdl/omv_cos_lut.sv =====
// Signed cosine of a whole-degree angle 0..359 from the quarter-wave table.
`timescale 1ns / 1ps
`default_nettype none

module omv_cos_lut #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic [8:0]                angle,
	output logic signed [FRAC_BITS+1:0]    cos_val
);

	localparam int SH   = 16 - FRAC_BITS;
	localparam int HALF = (1 << SH) >> 1;
	localparam int MW   = FRAC_BITS + 1;

	logic        negate;
	logic        mirror;
	logic [8:0]  rem;
	logic [6:0]  idx;
	logic [17:0] rounded;
	logic [MW-1:0] mag;

	always_comb begin
		if (angle >= 9'd270) begin
			rem    = angle - 9'd270;
			negate = 1'b0;
			mirror = 1'b1;
		end else if (angle >= 9'd180) begin
			rem    = angle - 9'd180;
			negate = 1'b1;
			mirror = 1'b0;
		end else if (angle >= 9'd90) begin
			rem    = angle - 9'd90;
			negate = 1'b1;
			mirror = 1'b1;
		end else begin
			rem    = angle;
			negate = 1'b0;
			mirror = 1'b0;
		end
		idx     = mirror ? (7'd90 - rem[6:0]) : rem[6:0];
		// round the Q16 entry to the chosen fraction width
		rounded = {1'b0, omv_pkg::COS_Q16_TAB[idx]} + 18'(HALF);
		mag     = MW'(rounded >> SH);
		cos_val = negate ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_velocity_mixer.sv =====
// Top level: six-stage pipelined three-wheel omni inverse kinematics with saturation.
// Stages in order: decode/cos lookup, speed*cos, truncation, coefficient multiplies,
// wheel sums, clamp into the output register.
// Throughput: one command per cycle while out_ready is high; each stage holds only while
// the next one is full and stalled, so bubbles collapse.
// Reset: all stage valid bits clear and limit_q returns to 40; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_velocity_mixer #(
	parameter int COS_FRACTION_BITS = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire omv_pkg::omv_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output omv_pkg::omv_out_t     out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [omv_pkg::LIMIT_W-1:0] cfg_data
);

	localparam int F  = COS_FRACTION_BITS;
	localparam int CW = F + 2;
	localparam int PW = 16 + CW;
	localparam int CPW = omv_pkg::COMP_W;
	localparam int MPW = omv_pkg::PROD_W;
	localparam int SW  = omv_pkg::SUM_W;

	// configuration
	logic [omv_pkg::LIMIT_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= omv_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6     = !valid_s6 || out_ready;
	assign rdy5     = !valid_s5 || rdy6;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	// stage 1: decode and cosine lookup
	logic                   h_neg, h_big, h_ok;
	logic [8:0]             angle_x, angle_y, h9;
	logic signed [CW-1:0]   cos_x, cos_y;
	logic signed [CPW-1:0]  speed_x, turn_x, fw_d, fx_d, fy_d;
	logic                   stop_d;

	omv_cos_lut #(.FRAC_BITS(F)) u_cos_x (.angle(angle_x), .cos_val(cos_x));
	omv_cos_lut #(.FRAC_BITS(F)) u_cos_y (.angle(angle_y), .cos_val(cos_y));

	always_comb begin
		h_neg   = in_data.heading[15];
		h_big   = !h_neg && (in_data.heading > 16'sd359);
		h_ok    = !h_neg && !h_big;
		h9      = h_ok ? in_data.heading[8:0] : 9'd0;
		angle_x = h9;
		// sine as cosine of (h + 270) mod 360
		angle_y = (h9 >= 9'd90) ? (h9 - 9'd90) : (h9 + 9'd270);
		speed_x = {in_data.speed[15], in_data.speed};
		turn_x  = {in_data.turn[15], in_data.turn};
		stop_d  = 1'b0;
		if (in_data.mode) begin
			fx_d   = {in_data.x_cmd[15], in_data.x_cmd};
			fy_d   = {in_data.y_cmd[15], in_data.y_cmd};
			fw_d   = turn_x;
			stop_d = (in_data.x_cmd == 16'sd0) && (in_data.y_cmd == 16'sd0)
				&& (in_data.turn == 16'sd0);
		end else begin
			fx_d = '0;
			fy_d = '0;
			if (h_neg)      fw_d = -speed_x;
			else if (h_big) fw_d = speed_x;
			else            fw_d = turn_x;
		end
	end

	logic                  trans_s1, direct_s1, stop_s1;
	logic signed [15:0]    speed_s1;
	logic signed [CW-1:0]  cosx_s1, cosy_s1;
	logic signed [CPW-1:0] fx_s1, fy_s1, fw_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			trans_s1  <= !in_data.mode && h_ok;
			direct_s1 <= in_data.mode;
			stop_s1   <= stop_d;
			speed_s1  <= in_data.speed;
			cosx_s1   <= cos_x;
			cosy_s1   <= cos_y;
			fx_s1     <= fx_d;
			fy_s1     <= fy_d;
			fw_s1     <= fw_d;
		end
	end

	// stage 2: speed times cosine
	logic                  trans_s2, direct_s2, stop_s2;
	logic signed [PW-1:0]  px_s2, py_s2;
	logic signed [CPW-1:0] fx_s2, fy_s2, fw_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			trans_s2  <= trans_s1;
			direct_s2 <= direct_s1;
			stop_s2   <= stop_s1;
			px_s2     <= PW'(speed_s1) * PW'(cosx_s1);
			py_s2     <= PW'(speed_s1) * PW'(cosy_s1);
			fx_s2     <= fx_s1;
			fy_s2     <= fy_s1;
			fw_s2     <= fw_s1;
		end
	end

	// stage 3: drop fraction bits, truncating toward zero
	logic signed [PW-1:0] ax, ay, tx, ty;

	always_comb begin
		ax = px_s2[PW-1] ? -px_s2 : px_s2;
		ay = py_s2[PW-1] ? -py_s2 : py_s2;
		tx = $signed(ax >>> F);
		ty = $signed(ay >>> F);
		if (px_s2[PW-1]) tx = -tx;
		if (py_s2[PW-1]) ty = -ty;
	end

	logic                  direct_s3, stop_s3;
	logic signed [CPW-1:0] fx_s3, fy_s3, fw_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			direct_s3 <= direct_s2;
			stop_s3   <= stop_s2;
			fx_s3     <= trans_s2 ? CPW'(tx) : fx_s2;
			fy_s3     <= trans_s2 ? CPW'(ty) : fy_s2;
			fw_s3     <= fw_s2;
		end
	end

	// stage 4: coefficient products
	logic signed [omv_pkg::COEF_W-1:0] cx_sel, cw_sel;

	assign cx_sel = direct_s3 ? omv_pkg::CX_DIRECT : omv_pkg::CX_POLAR;
	assign cw_sel = direct_s3 ? omv_pkg::CW_DIRECT : omv_pkg::CW_POLAR;

	logic                  stop_s4;
	logic signed [MPW-1:0] mx_s4, my_s4, mb_s4, mw_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			stop_s4 <= stop_s3;
			mx_s4   <= MPW'(fx_s3) * MPW'(cx_sel);
			my_s4   <= MPW'(fy_s3) * MPW'(omv_pkg::CY_ALL);
			mb_s4   <= MPW'(fy_s3) * MPW'(omv_pkg::CB_ALL);
			mw_s4   <= MPW'(fw_s3) * MPW'(cw_sel);
		end
	end

	// stage 5: wheel sums
	logic                 stop_s5;
	logic signed [SW-1:0] sa_s5, sb_s5, sc_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			stop_s5 <= stop_s4;
			sa_s5   <= SW'(mw_s4) + SW'(mx_s4) + SW'(my_s4);
			sb_s5   <= SW'(mw_s4) - SW'(mb_s4);
			sc_s5   <= SW'(mw_s4) - SW'(mx_s4) + SW'(my_s4);
		end
	end

	// stage 6: clamp at +/- limit into the output register
	logic signed [SW-1:0] lim, lim_n, ca, cb, cc;

	function automatic logic signed [SW-1:0] clamp_sum(
		input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] hi,
		input logic signed [SW-1:0] lo
	);
		logic signed [SW-1:0] r;
		r = v;
		if (r >= hi) r = hi;
		if (r <= lo) r = lo;
		return r;
	endfunction

	always_comb begin
		lim   = $signed(SW'({limit_q, 16'd0}));
		lim_n = -lim;
		ca    = clamp_sum(sa_s5, lim, lim_n);
		cb    = clamp_sum(sb_s5, lim, lim_n);
		cc    = clamp_sum(sc_s5, lim, lim_n);
	end

	omv_pkg::omv_out_t res_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			res_s6.wheel_a  <= ca[23:0];
			res_s6.wheel_b  <= cb[23:0];
			res_s6.wheel_c  <= cc[23:0];
			res_s6.stop_now <= stop_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = res_s6;

endmodule

`default_nettype wire
